>>> rtl/spcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spcw_pkg
// Shared types and constants of the server power-cycle watchdog: event
// codes, sequence phases, register indexes and register reset values.
// ----------------------------------------------------------------------------
package spcw_pkg;

   // Events carried in the op field of an input item
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_KICK    = 3'd1,
      OP_ENABLE  = 3'd2,
      OP_DISABLE = 3'd3,
      OP_REBOOT  = 3'd4
   } op_type;

   // Power-cycle sequence phases
   typedef enum logic [2:0] {
      PH_READY      = 3'd0,
      PH_CUT        = 3'd1,
      PH_WAIT_POWER = 3'd2,
      PH_PRESS      = 3'd3,
      PH_WAIT_BOOT  = 3'd4
   } phase_type;

   // Configuration register indexes (byte address / 4)
   localparam logic [2:0] REG_POWER_CUT    = 3'd0;
   localparam logic [2:0] REG_POWER_WAIT   = 3'd1;
   localparam logic [2:0] REG_BUTTON_PRESS = 3'd2;
   localparam logic [2:0] REG_BOOT         = 3'd3;
   localparam logic [2:0] REG_KICK_TIMEOUT = 3'd4;

   localparam int unsigned TICKS_WIDTH = 16;
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register reset values
   localparam logic [TICKS_WIDTH-1:0] POWER_CUT_RESET    = 16'd15;
   localparam logic [TICKS_WIDTH-1:0] POWER_WAIT_RESET   = 16'd25;
   localparam logic [TICKS_WIDTH-1:0] BUTTON_PRESS_RESET = 16'd3;
   localparam logic [TICKS_WIDTH-1:0] BOOT_RESET         = 16'd1500;
   localparam logic [TICKS_WIDTH-1:0] KICK_TIMEOUT_RESET = 16'd30000;

endpackage
`default_nettype wire

>>> rtl/server_power_cycle_watchdog.sv
`default_nettype none
// ----------------------------------------------------------------------------
// server_power_cycle_watchdog
// Power-cycle watchdog for one server: counts ticks, takes kicks and
// enable/disable/reboot events, and drives the power-cut and power-button
// lines through a five-phase sequence.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// req_      in   tvalid/tready      tdata: op[2:0], power_good[3]
// rsp_      out  tvalid/tready      tdata: power_cut[0], power_button[1],
//                                          phase[4:2], enabled[5]
// csr_      in   psel/penable/...   five 16-bit tick registers at 4*i
//
// One item per cycle while results are being taken; the result is registered:
// the event, the tick counter step and the phase update are one pass of logic
// from the state registers into the result register.
// The result register frees itself in the cycle it is taken, so req_tready
// stays high while the consumer takes results; a stalled result holds only
// the input side.
// Synchronous reset returns the phase to ready, clears the counter, the
// flags and both drives, and loads the register defaults.

module server_power_cycle_watchdog #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] op, [3] power_good, [7:4] zero

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] power_cut, [1] power_button,
                                         // [4:2] phase, [5] enabled, [7:6] zero

   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [spcw_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [spcw_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [spcw_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                       csr_pready
);

   localparam int unsigned TW = spcw_pkg::TICKS_WIDTH;
   localparam int unsigned EXT_WIDTH = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [TW-1:0] power_cut_ticks_ff;
   logic [TW-1:0] power_wait_ticks_ff;
   logic [TW-1:0] button_press_ticks_ff;
   logic [TW-1:0] boot_ticks_ff;
   logic [TW-1:0] kick_timeout_ticks_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         power_cut_ticks_ff    <= spcw_pkg::POWER_CUT_RESET;
         power_wait_ticks_ff   <= spcw_pkg::POWER_WAIT_RESET;
         button_press_ticks_ff <= spcw_pkg::BUTTON_PRESS_RESET;
         boot_ticks_ff         <= spcw_pkg::BOOT_RESET;
         kick_timeout_ticks_ff <= spcw_pkg::KICK_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            spcw_pkg::REG_POWER_CUT:    power_cut_ticks_ff    <= csr_pwdata[TW-1:0];
            spcw_pkg::REG_POWER_WAIT:   power_wait_ticks_ff   <= csr_pwdata[TW-1:0];
            spcw_pkg::REG_BUTTON_PRESS: button_press_ticks_ff <= csr_pwdata[TW-1:0];
            spcw_pkg::REG_BOOT:         boot_ticks_ff         <= csr_pwdata[TW-1:0];
            spcw_pkg::REG_KICK_TIMEOUT: kick_timeout_ticks_ff <= csr_pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         spcw_pkg::REG_POWER_CUT:    csr_prdata[TW-1:0] = power_cut_ticks_ff;
         spcw_pkg::REG_POWER_WAIT:   csr_prdata[TW-1:0] = power_wait_ticks_ff;
         spcw_pkg::REG_BUTTON_PRESS: csr_prdata[TW-1:0] = button_press_ticks_ff;
         spcw_pkg::REG_BOOT:         csr_prdata[TW-1:0] = boot_ticks_ff;
         spcw_pkg::REG_KICK_TIMEOUT: csr_prdata[TW-1:0] = kick_timeout_ticks_ff;
         default: ;
      endcase
   end

   // Counter load values: register values fitted to the counter width
   // (zero-extend when wider, drop upper bits when narrower).
   logic [EXT_WIDTH-1:0] cut_load_ext, wait_load_ext, press_load_ext;
   logic [EXT_WIDTH-1:0] boot_load_ext, kick_load_ext;
   logic [COUNT_WIDTH-1:0] cut_load, wait_load, press_load, boot_load, kick_load;

   assign cut_load_ext   = EXT_WIDTH'(power_cut_ticks_ff);
   assign wait_load_ext  = EXT_WIDTH'(power_wait_ticks_ff);
   assign press_load_ext = EXT_WIDTH'(button_press_ticks_ff);
   assign boot_load_ext  = EXT_WIDTH'(boot_ticks_ff);
   assign kick_load_ext  = EXT_WIDTH'(kick_timeout_ticks_ff);

   assign cut_load   = cut_load_ext[COUNT_WIDTH-1:0];
   assign wait_load  = wait_load_ext[COUNT_WIDTH-1:0];
   assign press_load = press_load_ext[COUNT_WIDTH-1:0];
   assign boot_load  = boot_load_ext[COUNT_WIDTH-1:0];
   assign kick_load  = kick_load_ext[COUNT_WIDTH-1:0];

   // ------------------------------------------------------------------
   // Watchdog state
   // ------------------------------------------------------------------
   spcw_pkg::phase_type    phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   expired_ff, expired_in;
   logic                   enable_ff, enable_in;
   logic                   cut_ff, cut_in;
   logic                   button_ff, button_in;

   logic             rsp_tvalid_ff;
   logic [7:0]       rsp_tdata_ff;
   logic             req_fire;
   spcw_pkg::op_type req_op;
   logic             req_pg;

   assign req_op     = spcw_pkg::op_type'(req_tdata[2:0]);
   assign req_pg     = req_tdata[3];
   // Accept whenever the result register is empty or being drained
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      expired_in = expired_ff;
      enable_in  = enable_ff;
      cut_in     = cut_ff;
      button_in  = button_ff;

      // Apply the event
      case (req_op)
         spcw_pkg::OP_TICK: begin
            // Count only while enabled, not yet expired and not at zero
            if (enable_ff && !expired_ff && (count_ff != '0)) begin
               count_in = count_ff - COUNT_WIDTH'(1);
               if (count_in == '0) begin
                  expired_in = 1'b1;
               end
            end
         end
         spcw_pkg::OP_KICK: begin
            count_in = kick_load;
         end
         spcw_pkg::OP_ENABLE: begin
            if (!enable_ff) begin
               enable_in = 1'b1;
               if (!req_pg) begin
                  cut_in   = 1'b1;
                  phase_in = spcw_pkg::PH_CUT;
                  count_in = cut_load;
               end else begin
                  phase_in = spcw_pkg::PH_WAIT_BOOT;
                  count_in = boot_load;
               end
            end
         end
         spcw_pkg::OP_DISABLE: begin
            // Release the drives; keep phase and any pending expiry
            enable_in = 1'b0;
            cut_in    = 1'b0;
            button_in = 1'b0;
         end
         spcw_pkg::OP_REBOOT: begin
            cut_in   = 1'b1;
            phase_in = spcw_pkg::PH_CUT;
            count_in = cut_load;
         end
         default: ;
      endcase

      // Advance the sequence once, on the state after the event
      unique case (phase_in)
         spcw_pkg::PH_CUT: begin
            if (expired_in) begin
               expired_in = 1'b0;
               cut_in     = 1'b0;
               phase_in   = spcw_pkg::PH_WAIT_POWER;
               count_in   = wait_load;
            end
         end
         spcw_pkg::PH_WAIT_POWER: begin
            if (req_pg) begin
               phase_in = spcw_pkg::PH_WAIT_BOOT;
               count_in = boot_load;
            end else if (expired_in) begin
               expired_in = 1'b0;
               button_in  = 1'b1;
               phase_in   = spcw_pkg::PH_PRESS;
               count_in   = press_load;
            end
         end
         spcw_pkg::PH_PRESS: begin
            if (expired_in) begin
               expired_in = 1'b0;
               button_in  = 1'b0;
               phase_in   = spcw_pkg::PH_WAIT_POWER;
               count_in   = wait_load;
            end
         end
         spcw_pkg::PH_WAIT_BOOT: begin
            if (expired_in) begin
               expired_in = 1'b0;
               phase_in   = spcw_pkg::PH_READY;
               count_in   = kick_load;
            end
         end
         spcw_pkg::PH_READY: begin
            // Timed out with no kick: power-cycle the server
            if (expired_in) begin
               expired_in = 1'b0;
               cut_in     = 1'b1;
               phase_in   = spcw_pkg::PH_CUT;
               count_in   = cut_load;
            end
         end
         default: ;
      endcase
   end

   // Hold state between items; update only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= spcw_pkg::PH_READY;
         count_ff   <= '0;
         expired_ff <= 1'b0;
         enable_ff  <= 1'b0;
         cut_ff     <= 1'b0;
         button_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         expired_ff <= expired_in;
         enable_ff  <= enable_in;
         cut_ff     <= cut_in;
         button_ff  <= button_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tdata_ff <= {2'b00, enable_in, phase_in, button_in, cut_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // Every accepted item leaves a result in the register
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid_ff)
      else $error("accepted item produced no result");

   // State moves only on an accepted item
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff) && $stable(count_ff) && $stable(expired_ff))
      else $error("watchdog state changed without an item");

   // A pending result shows the current phase
   a_phase_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[4:2] == phase_ff))
      else $error("result phase differs from phase register");

   // Disable always releases both drives and clears the enable flag
   a_disable_releases: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == spcw_pkg::OP_DISABLE) |=>
         !rsp_tdata_ff[0] && !rsp_tdata_ff[1] && !rsp_tdata_ff[5])
      else $error("disable left a drive or the enable flag set");
`endif

endmodule
`default_nettype wire

>>> tb/sv/spcw_watchdog_checker.sv
// ----------------------------------------------------------------------------
// spcw_watchdog_checker
// Watches the event, result and register channels of the power-cycle
// watchdog, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module spcw_watchdog_checker #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [2:0] op, [3] power_good
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [7:0]                            rsp_tdata,   // [0] power_cut, [1] power_button,
                                                              // [4:2] phase, [5] enabled
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic                                  csr_pready,
   input  logic [spcw_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [spcw_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output int                                    mismatches,
   output int                                    pending,
   output int                                    checked,
   output logic [4:0]                            phases_reached
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                enabled;
      spcw_pkg::phase_type phase;
      logic                power_button;
      logic                power_cut;
   } drive_state_type;

   logic [spcw_pkg::TICKS_WIDTH-1:0] tick_limit [0:4];
   spcw_pkg::phase_type    phase_now;
   logic [COUNT_WIDTH-1:0] countdown;
   logic                   expired;
   logic                   armed;
   logic                   cut_on;
   logic                   button_on;
   drive_state_type        drives_q[$];
   int                     fails;
   int                     seen;

   function automatic logic [COUNT_WIDTH-1:0] load_ticks(logic [2:0] idx);
      return COUNT_WIDTH'(tick_limit[idx]);
   endfunction

   function automatic void begin_power_cut();
      cut_on = 1'b1;
      phase_now = spcw_pkg::PH_CUT;
      countdown = load_ticks(spcw_pkg::REG_POWER_CUT);
   endfunction

   // Apply one event, then run the phase sequence once; return the drives.
   function automatic drive_state_type apply_event(logic [2:0] op, logic pg);
      drive_state_type r;
      case (op)
         spcw_pkg::OP_TICK: begin
            if (armed && !expired && countdown != '0) begin
               countdown = countdown - 1'b1;
               if (countdown == '0) expired = 1'b1;
            end
         end
         spcw_pkg::OP_KICK: countdown = load_ticks(spcw_pkg::REG_KICK_TIMEOUT);
         spcw_pkg::OP_ENABLE: begin
            if (!armed) begin
               armed = 1'b1;
               if (!pg) begin
                  begin_power_cut();
               end else begin
                  phase_now = spcw_pkg::PH_WAIT_BOOT;
                  countdown = load_ticks(spcw_pkg::REG_BOOT);
               end
            end
         end
         spcw_pkg::OP_DISABLE: begin
            armed = 1'b0;
            cut_on = 1'b0;
            button_on = 1'b0;
         end
         spcw_pkg::OP_REBOOT: begin_power_cut();
         default: ;
      endcase

      case (phase_now)
         spcw_pkg::PH_CUT: begin
            if (expired) begin
               expired = 1'b0;
               cut_on = 1'b0;
               phase_now = spcw_pkg::PH_WAIT_POWER;
               countdown = load_ticks(spcw_pkg::REG_POWER_WAIT);
            end
         end
         spcw_pkg::PH_WAIT_POWER: begin
            // power good wins over a pending expiry and leaves it pending
            if (pg) begin
               phase_now = spcw_pkg::PH_WAIT_BOOT;
               countdown = load_ticks(spcw_pkg::REG_BOOT);
            end else if (expired) begin
               expired = 1'b0;
               button_on = 1'b1;
               phase_now = spcw_pkg::PH_PRESS;
               countdown = load_ticks(spcw_pkg::REG_BUTTON_PRESS);
            end
         end
         spcw_pkg::PH_PRESS: begin
            if (expired) begin
               expired = 1'b0;
               button_on = 1'b0;
               phase_now = spcw_pkg::PH_WAIT_POWER;
               countdown = load_ticks(spcw_pkg::REG_POWER_WAIT);
            end
         end
         spcw_pkg::PH_WAIT_BOOT: begin
            if (expired) begin
               expired = 1'b0;
               phase_now = spcw_pkg::PH_READY;
               countdown = load_ticks(spcw_pkg::REG_KICK_TIMEOUT);
            end
         end
         spcw_pkg::PH_READY: begin
            if (expired) begin
               expired = 1'b0;
               begin_power_cut();
            end
         end
         default: ;
      endcase

      r.power_cut = cut_on;
      r.power_button = button_on;
      r.phase = phase_now;
      r.enabled = armed;
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      drive_state_type want;
      drive_state_type got;
      if (reset) begin
         tick_limit[spcw_pkg::REG_POWER_CUT] = spcw_pkg::POWER_CUT_RESET;
         tick_limit[spcw_pkg::REG_POWER_WAIT] = spcw_pkg::POWER_WAIT_RESET;
         tick_limit[spcw_pkg::REG_BUTTON_PRESS] = spcw_pkg::BUTTON_PRESS_RESET;
         tick_limit[spcw_pkg::REG_BOOT] = spcw_pkg::BOOT_RESET;
         tick_limit[spcw_pkg::REG_KICK_TIMEOUT] = spcw_pkg::KICK_TIMEOUT_RESET;
         phase_now = spcw_pkg::PH_READY;
         countdown = '0;
         expired = 1'b0;
         armed = 1'b0;
         cut_on = 1'b0;
         button_on = 1'b0;
         drives_q.delete();
         fails = 0;
         seen = 0;
         phases_reached <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[4:2] <= spcw_pkg::REG_KICK_TIMEOUT)
            tick_limit[csr_paddr[4:2]] = csr_pwdata[spcw_pkg::TICKS_WIDTH-1:0];
         if (req_tvalid && req_tready) begin
            want = apply_event(req_tdata[2:0], req_tdata[3]);
            drives_q.push_back(want);
            phases_reached[want.phase] <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = drive_state_type'(rsp_tdata[5:0]);
            seen++;
            if (drives_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("result %0d arrived with no event outstanding (data %02h)",
                           seen, rsp_tdata);
            end else begin
               want = drives_q.pop_front();
               if (got.power_cut != want.power_cut || got.power_button != want.power_button ||
                   got.phase != want.phase || got.enabled != want.enabled) begin
                  fails++;
                  if (fails <= 10)
                     $display("result %0d: expected cut=%0b button=%0b phase=%0d en=%0b, %s",
                              seen, want.power_cut, want.power_button, want.phase,
                              want.enabled,
                              $sformatf("got cut=%0b button=%0b phase=%0d en=%0b",
                                        got.power_cut, got.power_button, got.phase,
                                        got.enabled));
               end
            end
         end
      end
      mismatches <= fails;
      pending <= drives_q.size();
      checked <= seen;
   end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the server power-cycle watchdog: a short directed
// event list at the reset register values, then random event streams under
// several tick settings, with random gaps on the event side and random
// stalls on the result side. A checker beside the block does the predicting.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 200;
   // Number of register setups run after the directed part
   localparam int TICK_SETUPS = 9;
   // Opcodes the block must treat as no event
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata   = '0;   // [2:0] op, [3] power_good, [7:4] zero
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [7:0]                 rsp_tdata;          // [0] power_cut, [1] power_button,
                                                   // [4:2] phase, [5] enabled
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [spcw_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr   = '0;
   logic [spcw_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata  = '0;
   logic [spcw_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   int          mismatches;
   int          pending;
   int          checked;
   logic [4:0]  phases_reached;

   // Stimulus knobs shared by the driving processes
   bit   req_steady;
   bit   rsp_steady;
   int   events_sent;
   logic power_level = 1'b1;

   wire req_fire = req_tvalid & req_tready;
   wire rsp_fire = rsp_tvalid & rsp_tready;
   wire csr_fire = csr_psel & csr_penable & csr_pwrite & csr_pready;

   server_power_cycle_watchdog #(.COUNT_WIDTH(16)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spcw_watchdog_checker #(.COUNT_WIDTH(16)) watch (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatches     (mismatches),
      .pending        (pending),
      .checked        (checked),
      .phases_reached (phases_reached)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one event item: idle a random gap first (none when steady), then hold it until taken.
   // Valid stays high across back-to-back items so it never toggles in one step.
   task automatic send_event(logic [2:0] op, logic pg);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, pg, op};
      do @(posedge clock); while (!req_tready);
      events_sent++;
   endtask

   // Draw one event. Mostly ticks so the counters actually run out and the
   // sequence walks through its phases; power good flips now and then and
   // otherwise stays put, the way a real supply sense behaves.
   task automatic random_event();
      int         pick;
      logic [2:0] op;
      if ($urandom_range(0, 99) < 12) power_level = ~power_level;
      pick = $urandom_range(0, 99);
      if (pick < 74)      op = spcw_pkg::OP_TICK;
      else if (pick < 82) op = spcw_pkg::OP_KICK;
      else if (pick < 88) op = spcw_pkg::OP_ENABLE;
      else if (pick < 91) op = spcw_pkg::OP_DISABLE;
      else if (pick < 95) op = spcw_pkg::OP_REBOOT;
      else                op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      send_event(op, power_level);
   endtask

   // One register write: setup cycle, then access until pready. Select is
   // left high so writes can follow back to back; the caller drops it.
   task automatic write_tick_reg(logic [2:0] idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'($urandom), value};   // upper half is don't-care noise
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
   endtask

   task automatic program_ticks(logic [15:0] cut_t, logic [15:0] wait_t,
                                logic [15:0] press_t, logic [15:0] boot_t,
                                logic [15:0] kick_t);
      write_tick_reg(spcw_pkg::REG_POWER_CUT, cut_t);
      write_tick_reg(spcw_pkg::REG_POWER_WAIT, wait_t);
      write_tick_reg(spcw_pkg::REG_BUTTON_PRESS, press_t);
      write_tick_reg(spcw_pkg::REG_BOOT, boot_t);
      write_tick_reg(spcw_pkg::REG_KICK_TIMEOUT, kick_t);
      csr_psel <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Drop valid and hold until every result is back; every event gives a
   // result, and the checker's pending count shows when none is left.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Result side: stall a random number of cycles per item, or none at all
   // during steady stretches. Start only once reset has let go.
   initial begin : result_sink
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = rsp_steady ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Hang detector: any handshake on any channel clears the quiet count.
   initial begin : hang_watch
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire || csr_fire) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed events at the reset tick values: unused codes, events while
      // disabled, enable with and without power, enable while enabled, and a
      // disable in the middle of a power cut.
      send_event(OP_SPARE7, 1'b0);
      send_event(spcw_pkg::OP_TICK, 1'b0);      // disabled: counter holds
      send_event(spcw_pkg::OP_KICK, 1'b1);
      send_event(spcw_pkg::OP_DISABLE, 1'b0);
      send_event(spcw_pkg::OP_ENABLE, 1'b1);    // power present: straight to boot wait
      send_event(spcw_pkg::OP_ENABLE, 1'b0);    // already enabled: ignored
      send_event(spcw_pkg::OP_TICK, 1'b1);
      send_event(OP_SPARE5, 1'b1);
      send_event(spcw_pkg::OP_REBOOT, 1'b1);
      send_event(spcw_pkg::OP_TICK, 1'b0);
      send_event(spcw_pkg::OP_DISABLE, 1'b0);   // drives drop, phase stays
      send_event(spcw_pkg::OP_TICK, 1'b0);
      send_event(spcw_pkg::OP_ENABLE, 1'b0);    // no power: reboot
      send_event(OP_SPARE6, 1'b0);
      send_event(spcw_pkg::OP_KICK, 1'b0);
      send_event(spcw_pkg::OP_TICK, 1'b1);
      send_event(spcw_pkg::OP_REBOOT, 1'b0);
      send_event(spcw_pkg::OP_DISABLE, 1'b1);
      drain();

      for (int s = 0; s < TICK_SETUPS; s++) begin
         case (s)
            0: program_ticks(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            1: program_ticks(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            // zero loads: button press and kick reload never run out
            2: program_ticks(16'd2, 16'd3, 16'd0, 16'd4, 16'd0);
            default: program_ticks(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                                   16'($urandom_range(1, 4)), 16'($urandom_range(1, 10)),
                                   16'($urandom_range(1, 12)));
         endcase
         req_steady = (s == 3) || ($urandom_range(0, 3) == 0);
         rsp_steady = (s == 3) || ($urandom_range(0, 3) == 0);
         items = (s == 1) ? 60 : 124;
         repeat (items) random_event();
         drain();
      end

      $display("%0d events over reset values and %0d tick setups, %0d results compared",
               events_sent, TICK_SETUPS, checked);
      $display("phases reached (one bit per phase, ready lowest): %05b", phases_reached);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
